// ===== rtl/core/tlb_pkg.sv =====
// ----------------------------------------------------------------------------
// tlb_pkg
// Types and constants shared by the four-entry translation buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package tlb_pkg;

  localparam int unsigned PAGE_BYTES_DEF     = 128;
  localparam int unsigned PHYS_PAGES_DEF     = 32;
  localparam int unsigned VIRT_PAGE_BITS_DEF = 9;

  localparam int unsigned SLOTS  = 4;
  localparam int unsigned SLOT_W = 2;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_REFILL = 1'b1;

  localparam logic [1:0] KIND_INVALID = 2'd0;
  localparam logic [1:0] KIND_UNUSED  = 2'd1;
  localparam logic [1:0] KIND_RANDOM  = 2'd2;

  typedef struct packed {
    logic        action;
    logic [15:0] virtual_address;
    logic [11:0] physical_address;
    logic        read_only;
    logic [15:0] pc_address;
    logic [1:0]  random_pick;
  } tlb_req_t;

  typedef struct packed {
    logic        hit;
    logic [11:0] translated_address;
    logic [1:0]  written_slot;
    logic [1:0]  victim_kind;
  } tlb_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/tlb_lookup_and_refill_top.sv =====
// ----------------------------------------------------------------------------
// tlb_lookup_and_refill_top
// Four-entry translation buffer: lookup with use-bit marking, and refill with
// invalid / unused / random victim choice around the protected PC page.
// ----------------------------------------------------------------------------
// A request is taken on any cycle with start high (busy never rises). Its
// result appears with done high for one cycle: it passes the request register,
// then the entry compare and victim pick into the result register, which is
// loaded on the same edge at which the entries are updated. One request per
// cycle is sustained, and each request sees the entries as left by the one
// before it. There is no way to hold a result off: the receiver must take it
// in the cycle done is high.
`default_nettype none

module tlb_lookup_and_refill_top
  import tlb_pkg::*;
#(
  parameter int unsigned PAGE_BYTES     = PAGE_BYTES_DEF,
  parameter int unsigned PHYS_PAGES     = PHYS_PAGES_DEF,
  parameter int unsigned VIRT_PAGE_BITS = VIRT_PAGE_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire tlb_req_t request,
  output logic          busy,
  output logic          done,
  output tlb_rsp_t      result
);

  localparam int unsigned OFF_W  = $clog2(PAGE_BYTES);
  localparam int unsigned PPN_W  = (PHYS_PAGES > 1) ? $clog2(PHYS_PAGES) : 1;
  localparam int unsigned VPN_W  = VIRT_PAGE_BITS;
  localparam int unsigned WIDE_W = PPN_W + OFF_W + 12;

  tlb_req_t req_q;
  logic     req_v;

  logic               valid [SLOTS];
  logic               used  [SLOTS];
  logic [VPN_W-1:0]   vpage [SLOTS];
  logic [PPN_W-1:0]   ppage [SLOTS];
  logic               ro    [SLOTS];

  logic [VPN_W-1:0]   vpn;
  logic [VPN_W-1:0]   pc_vpn;
  logic [PPN_W-1:0]   new_ppn;
  logic [SLOTS-1:0]   hit_vec;
  logic [SLOTS-1:0]   prot_vec;
  logic [SLOTS-1:0]   inval_vec;
  logic [SLOTS-1:0]   unused_vec;
  logic               hit_any;
  logic [SLOT_W-1:0]  hit_idx;
  logic               prot_any;
  logic [SLOT_W-1:0]  prot_idx;
  logic               inval_any;
  logic [SLOT_W-1:0]  inval_idx;
  logic               unused_any;
  logic [SLOT_W-1:0]  unused_idx;
  logic [1:0]         pick_m;
  logic [SLOT_W-1:0]  rand_idx;
  logic [SLOT_W-1:0]  victim;
  logic [1:0]         kind;
  logic [WIDE_W-1:0]  phys_wide;
  tlb_rsp_t           result_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_v <= 1'b0;
    end else begin
      req_v <= start && !busy;
    end
    if (start && !busy) begin
      req_q <= request;
    end
  end

  assign vpn     = VPN_W'(32'(req_q.virtual_address) >> OFF_W);
  assign pc_vpn  = VPN_W'(32'(req_q.pc_address) >> OFF_W);
  assign new_ppn = PPN_W'(32'(req_q.physical_address) >> OFF_W);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit_vec[i]  = valid[i] && (vpage[i] == vpn);
      prot_vec[i] = (vpage[i] == pc_vpn);
    end
  end

  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    prot_any = 1'b0;
    prot_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_any = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (prot_vec[i]) begin
        prot_any = 1'b1;
        prot_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      inval_vec[i]  = !valid[i] && !(prot_any && (prot_idx == SLOT_W'(i)));
      unused_vec[i] = !used[i]  && !(prot_any && (prot_idx == SLOT_W'(i)));
    end
  end

  always_comb begin
    inval_any  = 1'b0;
    inval_idx  = '0;
    unused_any = 1'b0;
    unused_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (inval_vec[i]) begin
        inval_any = 1'b1;
        inval_idx = SLOT_W'(i);
      end
      if (unused_vec[i]) begin
        unused_any = 1'b1;
        unused_idx = SLOT_W'(i);
      end
    end
  end

  // pick of 3 behaves as 0; no protected entry counts as index 4 (0 mod 4)
  assign pick_m   = (req_q.random_pick == 2'd3) ? 2'd0 : req_q.random_pick;
  assign rand_idx = SLOT_W'(pick_m + 2'd1 + (prot_any ? prot_idx : SLOT_W'(0)));

  always_comb begin
    if (inval_any) begin
      victim = inval_idx;
      kind   = KIND_INVALID;
    end else if (unused_any) begin
      victim = unused_idx;
      kind   = KIND_UNUSED;
    end else begin
      victim = rand_idx;
      kind   = KIND_RANDOM;
    end
  end

  assign phys_wide = WIDE_W'({ppage[hit_idx], req_q.virtual_address[OFF_W-1:0]});

  always_comb begin
    result_next = '0;
    case (req_q.action)
      ACT_LOOKUP: begin
        if (hit_any) begin
          result_next.hit                = 1'b1;
          result_next.translated_address = phys_wide[11:0];
        end
      end
      ACT_REFILL: begin
        result_next.written_slot = victim;
        result_next.victim_kind  = kind;
      end
      default: begin
        result_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        valid[i] <= 1'b0;
        used[i]  <= 1'b0;
        vpage[i] <= '0;
        ppage[i] <= '0;
        ro[i]    <= 1'b0;
      end
    end else begin
      done <= req_v;
      if (req_v) begin
        case (req_q.action)
          ACT_LOOKUP: begin
            if (hit_any) begin
              used[hit_idx] <= 1'b1;
            end
          end
          ACT_REFILL: begin
            valid[victim] <= 1'b1;
            used[victim]  <= 1'b0;
            vpage[victim] <= vpn;
            ppage[victim] <= new_ppn;
            ro[victim]    <= req_q.read_only;
          end
          default: begin
            valid[0] <= valid[0];
          end
        endcase
      end
    end
    if (req_v) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  a_done_follows_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(req_v))
    else $error("done without a request in flight");

  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    done && result.hit |-> (result.written_slot == 2'd0) && (result.victim_kind == KIND_INVALID))
    else $error("lookup hit carries refill fields");

  a_refill_valid: assert property (@(posedge clk) disable iff (rst)
    done && (result.victim_kind != KIND_INVALID) |-> valid[result.written_slot])
    else $error("refilled entry not valid");

  a_random_full: assert property (@(posedge clk) disable iff (rst)
    done && (result.victim_kind == KIND_RANDOM)
      |-> ($countones({valid[3], valid[2], valid[1], valid[0]}) >= 3))
    else $error("random victim while unprotected entries were invalid");

  a_hit_marks_used: assert property (@(posedge clk) disable iff (rst)
    done && result.hit |-> ({used[3], used[2], used[1], used[0]} != 4'b0000))
    else $error("lookup hit left no use bit set");
`endif

endmodule

`default_nettype wire
